// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the scanner RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define STL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define STL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/stl_pkg.sv =====
// Shared types, token codes and keyword tables for the script token lexer.
// No dependencies; used by stl_scan, stl_tokq and script_token_lexer.
`timescale 1ns / 1ps

package stl_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;

  // Most tokens one source byte can cause, and token queue depth.
  localparam int MAX_RUN = 3;
  localparam int QDEPTH  = 8;

  localparam logic [4:0] K_EOF      = 5'd0;
  localparam logic [4:0] K_IDENT    = 5'd1;
  localparam logic [4:0] K_NUMBER   = 5'd2;
  localparam logic [4:0] K_STRING   = 5'd3;
  localparam logic [4:0] K_KEYWORD0 = 5'd4;
  localparam logic [4:0] K_OP0      = 5'd14;
  localparam logic [4:0] K_ERROR    = 5'd23;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam int NUM_KW = 10;
  localparam int NUM_OP = 9;

  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"f", "u", "n", "c", "t", "i", "o", "n"},
    '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "o", "c", "a", "l", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd5, 4'd8, 4'd3, 4'd4, 4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd6
  };

  localparam logic [7:0] OP_CHARS [NUM_OP] = '{
    "(", ")", "+", "-", "*", "/", "=", ">", "<"
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic        last;
  } token_t;

  // Tokens caused by one byte, in order, with their number.
  typedef struct packed {
    token_t [MAX_RUN-1:0] tok;
    logic   [1:0]         count;
  } burst_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic [$clog2(QDEPTH+1)-1:0] count;
    logic                        room;
  } qstat_t;

  function automatic logic is_letter(input logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return (l >= "a") && (l <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  // Drop keywords that no longer match at character index idx.
  function automatic logic [NUM_KW-1:0] narrow(input logic [NUM_KW-1:0] c,
                                               input logic [15:0] idx,
                                               input logic [7:0] b);
    logic [NUM_KW-1:0] r;
    r = c;
    for (int k = 0; k < NUM_KW; k++) begin
      if ((idx >= 16'(KW_LEN[k])) || (KW_TEXT[k][idx[2:0]] != b)) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [4:0] ident_kind(input logic [NUM_KW-1:0] c,
                                            input logic [15:0] len);
    logic [4:0] r;
    r = K_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (c[k] && (len == 16'(KW_LEN[k]))) r = K_KEYWORD0 + 5'(k);
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v, input logic [1:0] d);
    logic [16:0] s;
    s = 17'(v) + 17'(d);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

// ===== rtl/stl_scan.sv =====
// Scan state and per-byte token logic of the script token lexer.
// Depends on stl_pkg; produces a burst of up to three tokens per byte.
`timescale 1ns / 1ps

module stl_scan import stl_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  output burst_t     burst
);

  localparam int SW = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  typedef enum logic [5:0] {
    M_IDLE     = 6'b000001,
    M_IDENT    = 6'b000010,
    M_NUMBER   = 6'b000100,
    M_NUMDOT   = 6'b001000,
    M_FRACTION = 6'b010000,
    M_STRING   = 6'b100000
  } mode_t;

  mode_t                    mode, mode_next;
  logic [POSITION_BITS-1:0] token_begin, token_begin_next;
  logic [15:0]              token_len, token_len_next;
  logic [15:0]              line_count, line_count_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [NUM_KW-1:0]        cand, cand_next;

  logic [SW-1:0]            dot_sum;
  logic [POSITION_BITS-1:0] dot_pos;
  logic [POSITION_BITS:0]   pos_sum;
  logic                     fresh;
  logic [1:0]               n;
  logic                     is_op;
  logic [4:0]               op_kind;

  function automatic logic [15:0] start16(input logic [POSITION_BITS-1:0] v);
    logic [SW-1:0] w;
    w = SW'(v);
    return w[15:0];
  endfunction

  always_comb begin
    dot_sum = SW'(token_begin) + SW'(token_len);
    dot_pos = (dot_sum > SW'(POS_MAX)) ? POS_MAX : dot_sum[POSITION_BITS-1:0];
    pos_sum = (POSITION_BITS+1)'(byte_position) + (POSITION_BITS+1)'(1);
    is_op   = 1'b0;
    op_kind = K_ERROR;
    for (int k = 0; k < NUM_OP; k++) begin
      if (byte_in == OP_CHARS[k]) begin
        is_op   = 1'b1;
        op_kind = K_OP0 + 5'(k);
      end
    end
  end

  always_comb begin
    mode_next          = mode;
    token_begin_next   = token_begin;
    token_len_next     = token_len;
    line_count_next    = line_count;
    byte_position_next = byte_position;
    cand_next          = cand;
    fresh              = 1'b1;
    n                  = 2'd0;
    burst              = '0;
    for (int i = 0; i < MAX_RUN; i++) burst.tok[i].line = line_count;

    case (mode)
      M_IDENT: begin
        if (is_letter(byte_in) || is_digit(byte_in) || (byte_in == CH_UNDER)) begin
          cand_next      = narrow(cand, token_len, byte_in);
          token_len_next = sat_inc16(token_len, 2'd1);
          fresh          = 1'b0;
        end else begin
          burst.tok[n].kind   = ident_kind(cand, token_len);
          burst.tok[n].start  = start16(token_begin);
          burst.tok[n].length = token_len;
          n = n + 2'd1;
        end
      end
      M_NUMBER: begin
        if (is_digit(byte_in)) begin
          token_len_next = sat_inc16(token_len, 2'd1);
          fresh          = 1'b0;
        end else if (byte_in == CH_DOT) begin
          mode_next = M_NUMDOT;
          fresh     = 1'b0;
        end else begin
          burst.tok[n].kind   = K_NUMBER;
          burst.tok[n].start  = start16(token_begin);
          burst.tok[n].length = token_len;
          n = n + 2'd1;
        end
      end
      M_NUMDOT: begin
        if (is_digit(byte_in)) begin
          token_len_next = sat_inc16(token_len, 2'd2);
          mode_next      = M_FRACTION;
          fresh          = 1'b0;
        end else begin
          // The held dot turns out not to start a fraction.
          burst.tok[n].kind   = K_NUMBER;
          burst.tok[n].start  = start16(token_begin);
          burst.tok[n].length = token_len;
          n = n + 2'd1;
          burst.tok[n].kind   = K_ERROR;
          burst.tok[n].start  = start16(dot_pos);
          burst.tok[n].length = 16'd1;
          n = n + 2'd1;
        end
      end
      M_FRACTION: begin
        if (is_digit(byte_in)) begin
          token_len_next = sat_inc16(token_len, 2'd1);
          fresh          = 1'b0;
        end else begin
          burst.tok[n].kind   = K_NUMBER;
          burst.tok[n].start  = start16(token_begin);
          burst.tok[n].length = token_len;
          n = n + 2'd1;
        end
      end
      M_STRING: begin
        fresh = 1'b0;
        if (byte_in == CH_QUOTE) begin
          token_len_next      = sat_inc16(token_len, 2'd1);
          burst.tok[n].kind   = K_STRING;
          burst.tok[n].start  = start16(token_begin);
          burst.tok[n].length = sat_inc16(token_len, 2'd1);
          n = n + 2'd1;
          mode_next = M_IDLE;
        end else if (byte_in == CH_NUL) begin
          // Unterminated string: error, then end of source.
          burst.tok[n].kind   = K_ERROR;
          burst.tok[n].start  = start16(token_begin);
          burst.tok[n].length = token_len;
          n = n + 2'd1;
          burst.tok[n].kind   = K_EOF;
          burst.tok[n].start  = start16(byte_position);
          burst.tok[n].length = 16'd0;
          n = n + 2'd1;
          mode_next          = M_IDLE;
          token_begin_next   = '0;
          token_len_next     = '0;
          line_count_next    = 16'd1;
          byte_position_next = '0;
          cand_next          = '0;
        end else begin
          token_len_next = sat_inc16(token_len, 2'd1);
        end
      end
      default: begin
      end
    endcase

    if (fresh) begin
      mode_next = M_IDLE;
      if (byte_in == CH_NUL) begin
        burst.tok[n].kind   = K_EOF;
        burst.tok[n].start  = start16(byte_position);
        burst.tok[n].length = 16'd0;
        n = n + 2'd1;
        token_begin_next   = '0;
        token_len_next     = '0;
        line_count_next    = 16'd1;
        byte_position_next = '0;
        cand_next          = '0;
      end else if ((byte_in == CH_SPACE) || (byte_in == CH_TAB) || (byte_in == CH_CR)) begin
      end else if (byte_in == CH_LF) begin
        line_count_next = sat_inc16(line_count, 2'd1);
      end else if (is_letter(byte_in) || (byte_in == CH_UNDER)) begin
        mode_next        = M_IDENT;
        token_begin_next = byte_position;
        token_len_next   = 16'd1;
        cand_next        = narrow({NUM_KW{1'b1}}, 16'd0, byte_in);
      end else if (is_digit(byte_in)) begin
        mode_next        = M_NUMBER;
        token_begin_next = byte_position;
        token_len_next   = 16'd1;
      end else if (byte_in == CH_QUOTE) begin
        mode_next        = M_STRING;
        token_begin_next = byte_position;
        token_len_next   = 16'd1;
      end else begin
        // Operator, or an unknown byte reported as an error.
        burst.tok[n].kind   = is_op ? op_kind : K_ERROR;
        burst.tok[n].start  = start16(byte_position);
        burst.tok[n].length = 16'd1;
        n = n + 2'd1;
      end
    end

    if (byte_in != CH_NUL) begin
      byte_position_next = pos_sum[POSITION_BITS] ? POS_MAX
                                                  : pos_sum[POSITION_BITS-1:0];
    end

    if (n != 2'd0) burst.tok[n - 2'd1].last = 1'b1;
    burst.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      token_begin   <= '0;
      token_len     <= '0;
      line_count    <= 16'd1;
      byte_position <= '0;
      cand          <= '0;
    end else if (step) begin
      mode          <= mode_next;
      token_begin   <= token_begin_next;
      token_len     <= token_len_next;
      line_count    <= line_count_next;
      byte_position <= byte_position_next;
      cand          <= cand_next;
    end
  end

endmodule

// ===== rtl/stl_tokq.sv =====
// Token queue: takes a burst of up to three tokens a cycle, hands out one.
// Depends on stl_pkg for token_t, burst_t and qstat_t.
`timescale 1ns / 1ps

module stl_tokq import stl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  burst_t push,
  input  logic   pop,
  output token_t head,
  output logic   head_valid,
  output qstat_t stat
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  token_t          mem [QDEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count, count_next;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign count_next = count + CW'(push.count) - CW'(pop);
  assign stat.count = count;
  assign stat.room  = (count <= CW'(QDEPTH - MAX_RUN));

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RUN; i++) begin
      if (2'(i) < push.count) mem[wr_ptr + PW'(i)] <= push.tok[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      count <= count_next;
    end
  end

endmodule

// ===== rtl/script_token_lexer.sv =====
// Script token lexer: one source byte in per cycle while the token queue has room, tokens out one per transfer.
// A token is offered from the token queue after its byte has left the input register.
// Throughput: one byte per cycle while the eight-entry token queue keeps room
// for three tokens; a byte causes at most three tokens, handed out one per transfer.
// Reset (rst, synchronous): scan idle, line 1, offset 0, queue and input empty.
`timescale 1ns / 1ps

module script_token_lexer import stl_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // source byte channel
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  source_byte,
  // token channel
  output logic        tok_valid,
  input  logic        tok_stall,
  output logic [4:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [15:0] token_line,
  output logic        last_of_run
);

`include "assert_macros.svh"

  // Input register: one byte waiting for the scanner.
  logic       byte_valid;
  logic [7:0] byte_q;

  logic   step;
  logic   src_take;
  logic   pop;
  burst_t burst;
  token_t head;
  qstat_t qstat;

  // Drop the burst when the scanner is not stepping.
  function automatic burst_t step_burst(input burst_t b, input logic s);
    burst_t r;
    r = b;
    if (!s) r.count = 2'd0;
    return r;
  endfunction

  // Advance the scanner only when the queue can absorb a full burst.
  assign step      = byte_valid && qstat.room;
  // Stall only while the held byte cannot move on this cycle.
  assign src_stall = byte_valid && !qstat.room;
  assign src_take  = src_valid && !src_stall;
  assign pop       = tok_valid && !tok_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (src_take) begin
      byte_valid <= 1'b1;
    end else if (step) begin
      byte_valid <= 1'b0;
    end
  end

  // Load the payload on each transfer; hold it otherwise.
  always_ff @(posedge clk) begin
    if (src_take) byte_q <= source_byte;
  end

  stl_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .byte_in(byte_q),
    .burst  (burst)
  );

  stl_tokq u_tokq (
    .clk       (clk),
    .rst       (rst),
    .push      (step_burst(burst, step)),
    .pop       (pop),
    .head      (head),
    .head_valid(tok_valid),
    .stat      (qstat)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign token_line   = head.line;
  assign last_of_run  = head.last;

  // A byte that could not move on must still be held, unchanged, next cycle.
  `STL_ASSERT(a_hold_byte, (byte_valid && !step) |=> (byte_valid && $stable(byte_q)), "byte lost")
  // The queue never holds more than its depth.
  `STL_NEVER(a_q_over, qstat.count > ($clog2(QDEPTH + 1))'(QDEPTH), "token queue overflow")
  // Offered tokens carry a defined kind and a line of at least one.
  `STL_ASSERT(a_tok_sane, tok_valid |-> ((token_kind <= K_ERROR) && (token_line != 16'd0)), "bad token")
  // A scanner step is only taken with room for a full burst.
  `STL_ASSERT(a_step_room, step |=> (qstat.count <= ($clog2(QDEPTH + 1))'(QDEPTH)), "step without room")

endmodule

// ===== sim/script_token_lexer_tb.sv =====
// Self-checking testbench for script_token_lexer: directed table, then random sources,
// checked against hand-typed rows and a scanner model below.
// Depends on rtl/stl_pkg.sv (token codes, character codes) and the lexer RTL.
`timescale 1ns / 1ps

module script_token_lexer_tb;
  import stl_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 3;
  localparam int RANDOM_ITEMS  = 130;
  localparam int DRAIN_CYCLES  = 20;         // extra wait once every owed token has been seen
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [15:0] TOP16 = 16'hFFFF;

  // One expected (or observed) token.
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic        last;
  } lexeme_t;

  // Directed stimulus row; the token fields only count when typed is set.
  typedef struct packed {
    logic [7:0]  ch;
    logic        typed;
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
  } row_t;

  typedef enum logic [5:0] {
    SC_IDLE     = 6'b000001,
    SC_IDENT    = 6'b000010,
    SC_NUMBER   = 6'b000100,
    SC_HELD_DOT = 6'b001000,
    SC_FRACTION = 6'b010000,
    SC_STRING   = 6'b100000
  } scan_state_t;

  localparam int DIRECTED_ROWS = 28;

  // Opening rows: every operator and two unknown bytes straight after reset, where the
  // offsets are plain to read. Then a string across a newline, a number whose dot is
  // followed by a letter, a keyword ended by a newline, a fraction, an unterminated
  // string cut off by end of source, and a bare end of source after the scan restarts.
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{"(",      1'b1, K_OP0,          16'd0,  16'd1, 16'd1},
    '{")",      1'b1, K_OP0 + 5'd1,   16'd1,  16'd1, 16'd1},
    '{"+",      1'b1, K_OP0 + 5'd2,   16'd2,  16'd1, 16'd1},
    '{"-",      1'b1, K_OP0 + 5'd3,   16'd3,  16'd1, 16'd1},
    '{"*",      1'b1, K_OP0 + 5'd4,   16'd4,  16'd1, 16'd1},
    '{"/",      1'b1, K_OP0 + 5'd5,   16'd5,  16'd1, 16'd1},
    '{"=",      1'b1, K_OP0 + 5'd6,   16'd6,  16'd1, 16'd1},
    '{">",      1'b1, K_OP0 + 5'd7,   16'd7,  16'd1, 16'd1},
    '{"<",      1'b1, K_OP0 + 5'd8,   16'd8,  16'd1, 16'd1},
    '{8'hFF,    1'b1, K_ERROR,        16'd9,  16'd1, 16'd1},
    '{8'h01,    1'b1, K_ERROR,        16'd10, 16'd1, 16'd1},
    '{CH_LF,    1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{CH_QUOTE, 1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{CH_LF,    1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{CH_QUOTE, 1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{"7",      1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{CH_DOT,   1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{"e",      1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{"n",      1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{"d",      1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{CH_LF,    1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{"4",      1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{CH_DOT,   1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{"2",      1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{CH_QUOTE, 1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{8'h80,    1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{CH_NUL,   1'b0, K_EOF,          16'd0,  16'd0, 16'd0},
    '{CH_NUL,   1'b1, K_EOF,          16'd0,  16'd0, 16'd1}
  };

  string kw_words [10] = '{"print", "function", "end", "else", "if",
                           "then", "while", "do", "local", "return"};
  string op_set = "()+-*/=><";
  string junk_set = "!#$%&',:;?@[]^{|}~.";
  logic [7:0] blank_set [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        src_valid;
  logic        src_stall;
  logic [7:0]  source_byte;
  logic        tok_valid;
  logic        tok_stall;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic        last_of_run;

  // Scanner model state.
  scan_state_t mode;
  logic [15:0] tok_begin;
  logic [15:0] tok_len;
  logic [15:0] line_no;
  logic [15:0] offset;
  logic [9:0]  kw_live;

  lexeme_t produced [$];        // tokens caused by the byte just accepted
  lexeme_t awaited_tokens [$];  // tokens still owed by the block, oldest first

  int          mismatches = 0;
  int unsigned cycles = 0;
  int          src_gap_max = 17;
  int          sink_stall_max = 17;
  int          sunk = 0;
  int          fed = 0;
  int          kw_turn = 0;

  script_token_lexer dut (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .source_byte  (source_byte),
    .tok_valid    (tok_valid),
    .tok_stall    (tok_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .token_line   (token_line),
    .last_of_run  (last_of_run)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] d);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, d};
    return sum[16] ? TOP16 : sum[15:0];
  endfunction

  // Letters of either case, or underscore: anything that may open a name.
  function automatic bit name_char(input logic [7:0] b);
    logic [7:0] folded;
    folded = b | 8'h20;
    return (folded >= "a" && folded <= "z") || b == CH_UNDER;
  endfunction

  function automatic bit decimal(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // Keep only the keywords whose character at idx is b.
  task automatic drop_candidates(input logic [15:0] idx, input logic [7:0] b);
    for (int k = 0; k < 10; k++) begin
      if (kw_live[k] && (idx >= kw_words[k].len() || kw_words[k][idx] != b))
        kw_live[k] = 1'b0;
    end
  endtask

  // Lowest-numbered keyword still alive whose length matches wins.
  function automatic logic [4:0] word_kind();
    for (int k = 0; k < 10; k++) begin
      if (kw_live[k] && tok_len == 16'(kw_words[k].len())) return K_KEYWORD0 + 5'(k);
    end
    return K_IDENT;
  endfunction

  task automatic emit(input logic [4:0] kind, input logic [15:0] start,
                      input logic [15:0] length);
    produced.push_back('{kind, start, length, line_no, 1'b0});
  endtask

  task automatic clear_scan();
    mode = SC_IDLE;
    tok_begin = '0;
    tok_len = '0;
    line_no = 16'd1;
    offset = '0;
    kw_live = '0;
  endtask

  // Scan a byte with no token open.
  task automatic open_token(input logic [7:0] b, input logic [15:0] pos);
    int hit;
    hit = -1;
    mode = SC_IDLE;
    if (b == CH_NUL) begin
      emit(K_EOF, pos, 16'd0);
      clear_scan();
    end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
      // skip
    end else if (b == CH_LF) begin
      line_no = sat_add16(line_no, 16'd1);
    end else if (name_char(b)) begin
      mode = SC_IDENT;
      tok_begin = pos;
      tok_len = 16'd1;
      kw_live = '1;
      drop_candidates(16'd0, b);
    end else if (decimal(b)) begin
      mode = SC_NUMBER;
      tok_begin = pos;
      tok_len = 16'd1;
    end else if (b == CH_QUOTE) begin
      mode = SC_STRING;
      tok_begin = pos;
      tok_len = 16'd1;
    end else begin
      for (int k = 0; k < 9; k++) if (hit < 0 && op_set[k] == b) hit = k;
      if (hit >= 0) emit(K_OP0 + 5'(hit), pos, 16'd1);
      else emit(K_ERROR, pos, 16'd1);
    end
  endtask

  // Advance the model by one accepted byte; the tokens it causes land in produced.
  task automatic lex_byte(input logic [7:0] b);
    logic [15:0] pos;
    bit fresh;
    pos = offset;
    fresh = 1'b1;
    produced.delete();
    case (mode)
      SC_IDENT: begin
        if (name_char(b) || decimal(b)) begin
          drop_candidates(tok_len, b);
          tok_len = sat_add16(tok_len, 16'd1);
          fresh = 1'b0;
        end else begin
          emit(word_kind(), tok_begin, tok_len);
        end
      end
      SC_NUMBER: begin
        if (decimal(b)) begin
          tok_len = sat_add16(tok_len, 16'd1);
          fresh = 1'b0;
        end else if (b == CH_DOT) begin
          mode = SC_HELD_DOT;
          fresh = 1'b0;
        end else begin
          emit(K_NUMBER, tok_begin, tok_len);
        end
      end
      SC_HELD_DOT: begin
        if (decimal(b)) begin
          tok_len = sat_add16(tok_len, 16'd2);
          mode = SC_FRACTION;
          fresh = 1'b0;
        end else begin
          emit(K_NUMBER, tok_begin, tok_len);
          emit(K_ERROR, sat_add16(tok_begin, tok_len), 16'd1);
        end
      end
      SC_FRACTION: begin
        if (decimal(b)) begin
          tok_len = sat_add16(tok_len, 16'd1);
          fresh = 1'b0;
        end else begin
          emit(K_NUMBER, tok_begin, tok_len);
        end
      end
      SC_STRING: begin
        fresh = 1'b0;
        if (b == CH_QUOTE) begin
          tok_len = sat_add16(tok_len, 16'd1);
          emit(K_STRING, tok_begin, tok_len);
          mode = SC_IDLE;
        end else if (b == CH_NUL) begin
          emit(K_ERROR, tok_begin, tok_len);
          emit(K_EOF, pos, 16'd0);
          clear_scan();
        end else begin
          tok_len = sat_add16(tok_len, 16'd1);
        end
      end
      default: ;
    endcase
    if (fresh) open_token(b, pos);
    if (b != CH_NUL) offset = sat_add16(pos, 16'd1);
    if (produced.size() > 0) produced[produced.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  // Offer one byte after a random gap and hold it until the block takes it. Valid
  // stays high across back-to-back transfers so it is never dropped and raised in
  // the same step.
  task automatic transfer_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    source_byte <= b;
    do @(posedge clk); while (src_stall);
    fed++;
  endtask

  task automatic feed(input logic [7:0] b);
    transfer_byte(b);
    lex_byte(b);
    foreach (produced[j]) awaited_tokens.push_back(produced[j]);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] ch;
    ch = 8'("a" + $urandom_range(0, 25));
    return ($urandom_range(0, 3) == 0) ? (ch ^ 8'h20) : ch;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_name_tail();
    int r;
    r = $urandom_range(0, 37);
    if (r < 26) return rand_letter();
    if (r < 36) return rand_digit();
    return CH_UNDER;
  endfunction

  // Any byte but the closing quote and end of source may sit in a string.
  function automatic logic [7:0] rand_string_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(1, 255)); while (ch == CH_QUOTE);
    return ch;
  endfunction

  function automatic logic [7:0] rand_junk();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(128, 255));
      1: return junk_set[$urandom_range(0, junk_set.len() - 1)];
      2: return 8'($urandom_range(1, 8));
      default: return 8'h7F;
    endcase
  endfunction

  // One source: mostly well-formed lexemes with random content, ended by byte 0.
  // Roughly one source in six is raw noise instead.
  task automatic random_source();
    int lexemes;
    int cut;
    string word;
    case ($urandom_range(0, 2))
      0: src_gap_max = 0;
      1: src_gap_max = 4;
      default: src_gap_max = 17;
    endcase
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 10)) feed(8'($urandom_range(0, 255)));
      feed(CH_NUL);
      return;
    end
    lexemes = $urandom_range(1, 10);
    for (int i = 0; i < lexemes; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // walk the keyword list in turn so that each one comes up
          word = kw_words[kw_turn % 10];
          kw_turn++;
          for (int k = 0; k < word.len(); k++) feed(word[k]);
        end
        2: begin
          // near miss: a keyword cut short or run on
          word = kw_words[$urandom_range(0, 9)];
          cut = word.len() - $urandom_range(0, 1);
          for (int k = 0; k < cut; k++) feed(word[k]);
          if (cut == word.len()) feed(rand_name_tail());
        end
        3: begin
          feed(($urandom_range(0, 7) == 0) ? CH_UNDER : rand_letter());
          repeat ($urandom_range(0, 6)) feed(rand_name_tail());
        end
        4: begin
          repeat ($urandom_range(1, 4)) feed(rand_digit());
          if ($urandom_range(0, 1)) begin
            feed(CH_DOT);
            repeat ($urandom_range(0, 3)) feed(rand_digit());
          end
        end
        5: begin
          feed(CH_QUOTE);
          repeat ($urandom_range(0, 6)) feed(rand_string_char());
          if ($urandom_range(0, 7) == 0) begin
            // leave the string open and end the source inside it
            feed(CH_NUL);
            return;
          end
          feed(CH_QUOTE);
        end
        6, 9: feed(op_set[$urandom_range(0, 8)]);
        7: feed(blank_set[$urandom_range(0, 3)]);
        default: feed(rand_junk());
      endcase
      if ($urandom_range(0, 1)) feed(blank_set[$urandom_range(0, 3)]);
    end
    feed(CH_NUL);
  endtask

  // ---------------------------------------------------------------------------
  // Token side
  // ---------------------------------------------------------------------------

  // Stall for a random number of cycles before each transfer; every 25 tokens pick at random
  // either a stretch with no stalling or one with long stalls.
  initial begin : token_sink
    int hold;
    forever begin
      hold = $urandom_range(0, sink_stall_max);
      if (hold > 0) begin
        tok_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      tok_stall <= 1'b0;
      do @(posedge clk); while (rst || !tok_valid);
      sunk++;
      if (sunk % 25 == 0) sink_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Compare every transfer with the oldest token owed. Everything is sampled in the
  // active region of the edge, so the values seen are those from before the edge.
  always @(posedge clk) begin : check_tokens
    lexeme_t want;
    if (!rst && tok_valid && !tok_stall) begin
      if (awaited_tokens.size() == 0) begin
        flag_mismatch("token with nothing owed, kind", token_kind, 0);
      end else begin
        want = awaited_tokens.pop_front();
        if (token_kind !== want.kind) flag_mismatch("token_kind", token_kind, want.kind);
        if (token_start !== want.start)
          flag_mismatch("token_start", token_start, want.start);
        if (token_length !== want.length)
          flag_mismatch("token_length", token_length, want.length);
        if (token_line !== want.line) flag_mismatch("token_line", token_line, want.line);
        if (last_of_run !== want.last)
          flag_mismatch("last_of_run", last_of_run, want.last);
      end
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    src_valid <= 1'b0;
    source_byte <= CH_NUL;
    clear_scan();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table: typed rows stand for themselves, the rest follow the model.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      transfer_byte(DIRECTED[i].ch);
      lex_byte(DIRECTED[i].ch);
      if (DIRECTED[i].typed)
        awaited_tokens.push_back('{DIRECTED[i].kind, DIRECTED[i].start,
                                   DIRECTED[i].length, DIRECTED[i].line, 1'b1});
      else
        foreach (produced[j]) awaited_tokens.push_back(produced[j]);
    end

    // Random sources until enough bytes have gone in.
    fed = 0;
    while (fed < RANDOM_ITEMS) random_source();
    src_valid <= 1'b0;

    // Drain whatever is still owed, then give the pipeline a little longer.
    while (awaited_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_tokens.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
